>>> rtl/xbr_pkg.sv
// Shared types, constants and the seed mixing function of the bounded random source.
`timescale 1ns / 1ps
package xbr_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  localparam logic [WORD_W-1:0] DEFAULT_SEED = WORD_W'(123456789);
  localparam logic [WORD_W-1:0] WORD_MAX     = '1;

  // step shifts
  localparam int STEP_SH_X = 15;
  localparam int STEP_SH_W = 21;
  localparam int STEP_SH_T = 4;

  // seed mixing shifts
  localparam int MIX_SH_A = 13;
  localparam int MIX_SH_B = 17;
  localparam int MIX_SH_C = 5;

  typedef enum logic [1:0] {
    KIND_RESEED  = 2'd0,
    KIND_RAW32   = 2'd1,
    KIND_RAW64   = 2'd2,
    KIND_BOUNDED = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic mix_z;
    logic mix_w;
    logic step;
  } gen_ctrl_t;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = v;
    r = r ^ (r << MIX_SH_A);
    r = r ^ (r >> MIX_SH_B);
    r = r ^ (r << MIX_SH_C);
    return r;
  endfunction

  localparam logic [WORD_W-1:0] RESET_X = DEFAULT_SEED;
  localparam logic [WORD_W-1:0] RESET_Y = mix_word(RESET_X);
  localparam logic [WORD_W-1:0] RESET_Z = mix_word(RESET_Y);
  localparam logic [WORD_W-1:0] RESET_W = mix_word(RESET_Z);

endpackage

>>> rtl/xbr_gen.sv
// Xorshift state words with step and reseed logic.
`timescale 1ns / 1ps
module xbr_gen
  import xbr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gen_ctrl_t         ctrl_i,
  input  logic [WORD_W-1:0] seed_i,
  output logic [WORD_W-1:0] step_o
);

  logic [WORD_W-1:0] x_q, y_q, z_q, w_q;
  logic [WORD_W-1:0] x_d, y_d, z_d, w_d;
  logic [WORD_W-1:0] tx;
  logic [WORD_W-1:0] seed0;

  assign tx     = x_q ^ (x_q << STEP_SH_X);
  assign step_o = (w_q ^ (w_q >> STEP_SH_W)) ^ (tx ^ (tx >> STEP_SH_T));
  assign seed0  = (seed_i == '0) ? DEFAULT_SEED : seed_i;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    w_d = w_q;
    if (ctrl_i.load) begin
      x_d = seed0;
      y_d = mix_word(seed0);
    end else if (ctrl_i.mix_z) begin
      z_d = mix_word(y_q);
    end else if (ctrl_i.mix_w) begin
      w_d = mix_word(z_q);
    end else if (ctrl_i.step) begin
      x_d = y_q;
      y_d = z_q;
      z_d = w_q;
      w_d = step_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= RESET_X;
      y_q <= RESET_Y;
      z_q <= RESET_Z;
      w_q <= RESET_W;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      w_q <= w_d;
    end
  end

endmodule

>>> rtl/xbr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module xbr_div
  import xbr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_W - 1);

  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WORD_W-1:0] quo_q, rem_q, div_q;
  logic [WORD_W:0]   rem_shift;
  logic [WORD_W:0]   diff;
  logic              ge;

  // shift the next dividend bit into the partial remainder
  assign rem_shift = {rem_q, quo_q[WORD_W-1]};
  assign diff      = rem_shift - {1'b0, div_q};
  assign ge        = (rem_shift >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[WORD_W-2:0], ge};
      rem_q <= ge ? diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> rtl/xorshift_bounded_random.sv
// Top level: request sequencer, seed register and result register.
// Bounded draws run the bit-serial divider twice (by the bound, then by the scale), and each
// rejected step draws a fresh word; a zero bound skips the divider and returns zero.
// One request in work at a time; the next is taken the cycle after the result is registered.
// Reset restores the default-seed state and clears the seed register.
`timescale 1ns / 1ps
module xorshift_bounded_random
  import xbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [30:0]         bound_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2*WORD_W-1:0] value_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WORD_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIXZ,
    S_MIXW,
    S_LO,
    S_DIV1,
    S_DRAW,
    S_DIV2,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [WORD_W-1:0]   seed_q;
  logic [WORD_W-1:0]   hi_q;
  logic [WORD_W-1:0]   scale_q;
  logic [WORD_W-1:0]   limit_q;
  logic [2*WORD_W-1:0] res_q;
  logic                out_valid_q;
  logic [2*WORD_W-1:0] value_q;

  gen_ctrl_t         gen_ctrl;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [WORD_W-1:0] step;
  logic              accept;
  kind_e             kind;
  logic [WORD_W-1:0] bound_w;
  logic              draw_ok;
  logic              out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign kind     = kind_e'(kind_i);
  assign bound_w  = {{(WORD_W-31){1'b0}}, bound_i};
  assign draw_ok  = (step < limit_q);
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;

  always_comb begin
    gen_ctrl.load  = accept && (kind == KIND_RESEED);
    gen_ctrl.mix_z = (state_q == S_MIXZ);
    gen_ctrl.mix_w = (state_q == S_MIXW);
    gen_ctrl.step  = (accept && (kind == KIND_RAW32 || kind == KIND_RAW64)) ||
                     (state_q == S_LO) || (state_q == S_DRAW);
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = WORD_MAX;
    div_req.divisor  = bound_w;
    if (state_q == S_DRAW) begin
      div_req.start    = draw_ok;
      div_req.dividend = step;
      div_req.divisor  = scale_q;
    end else if (accept && kind == KIND_BOUNDED && bound_i != '0) begin
      div_req.start = 1'b1;
    end
  end

  xbr_gen u_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (gen_ctrl),
    .seed_i (seed_q),
    .step_o (step)
  );

  xbr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      seed_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once the far side takes it
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_RESEED: state_q <= S_MIXZ;
              KIND_RAW32:  state_q <= S_OUT;
              KIND_RAW64:  state_q <= S_LO;
              KIND_BOUNDED: begin
                state_q <= (bound_i == '0) ? S_OUT : S_DIV1;
              end
              default:     state_q <= S_OUT;
            endcase
          end
        end
        S_MIXZ: state_q <= S_MIXW;
        S_MIXW: state_q <= S_OUT;
        S_LO:   state_q <= S_OUT;
        S_DIV1: begin
          if (div_rsp.done) begin
            state_q <= S_DRAW;
          end
        end
        S_DRAW: begin
          if (draw_ok) begin
            state_q <= S_DIV2;
          end
        end
        S_DIV2: begin
          if (div_rsp.done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hi_q  <= step;
      res_q <= (kind == KIND_RAW32) ? {{WORD_W{1'b0}}, step} : '0;
    end
    if (state_q == S_LO) begin
      res_q <= {hi_q, step};
    end
    // limit is WORD_MAX minus the remainder; the scale divisor is the quotient
    if (state_q == S_DIV1 && div_rsp.done) begin
      scale_q <= div_rsp.quotient;
      limit_q <= WORD_MAX - div_rsp.remainder;
    end
    if (state_q == S_DIV2 && div_rsp.done) begin
      res_q <= {{WORD_W{1'b0}}, div_rsp.quotient};
    end
    if (state_q == S_OUT && out_free) begin
      value_q <= res_q;
    end
  end

endmodule

>>> tb/tb_xorshift_bounded_random.sv
// Testbench for the bounded xorshift random source: self-checking against a local predictor.
`timescale 1ns / 1ps
module tb_xorshift_bounded_random
  import xbr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct packed {
    kind_e       kind;
    logic [30:0] bound;
  } draw_req_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  kind_i      = 2'd0;
  logic [30:0] bound_i     = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] value_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  draw_req_t   draw_req_q[$];
  logic [63:0] want_value_q[$];
  logic [63:0] want_value;
  draw_req_t   taken_req;

  // predictor state
  logic [31:0] st_x, st_y, st_z, st_w;
  logic [31:0] seed_shadow;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_cnt        = 0;
  int idle_run;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;
  bit hold_used      = 1'b0;

  xorshift_bounded_random u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .bound_i     (bound_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] scramble(input logic [31:0] v);
    logic [31:0] r;
    r = v ^ (v << 13);
    r = r ^ (r >> 17);
    r = r ^ (r << 5);
    return r;
  endfunction

  function automatic void reseed_words(input logic [31:0] s);
    st_x = (s != 32'd0) ? s : DEFAULT_SEED;
    st_y = scramble(st_x);
    st_z = scramble(st_y);
    st_w = scramble(st_z);
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] t;
    t = st_x ^ (st_x << 15);
    t = (st_w ^ (st_w >> 21)) ^ (t ^ (t >> 4));
    st_x = st_y;
    st_y = st_z;
    st_z = st_w;
    st_w = t;
    return t;
  endfunction

  function automatic logic [63:0] predict_value(input kind_e kind, input logic [30:0] bound);
    logic [31:0] n;
    logic [31:0] limit;
    logic [31:0] s;
    logic [31:0] hi;
    n = {1'b0, bound};
    case (kind)
      KIND_RESEED: begin
        reseed_words(seed_shadow);
        return 64'd0;
      end
      KIND_RAW32: begin
        return {32'd0, next_word()};
      end
      KIND_RAW64: begin
        hi = next_word();
        return {hi, next_word()};
      end
      default: begin
        // bound zero leaves the generator untouched
        if (n == 32'd0) return 64'd0;
        limit = 32'hFFFF_FFFF - (32'hFFFF_FFFF % n);
        do s = next_word(); while (s >= limit);
        return {32'd0, s / ((limit - 32'd1) / n + 32'd1)};
      end
    endcase
  endfunction

  // driver: offer queued requests, predict on each transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        taken_req = draw_req_q.pop_front();
        want_value_q.push_back(predict_value(taken_req.kind, taken_req.bound));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (draw_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          kind_i     <= draw_req_q[0].kind;
          bound_i    <= draw_req_q[0].bound;
        end else begin
          in_valid_i <= 1'b0;
          kind_i     <= 2'($urandom);
          bound_i    <= 31'($urandom);
        end
      end
    end
  end

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (want_value_q.size() == 0) begin
          $error("value: expected none, actual %h", value_o);
          err_cnt++;
        end else begin
          want_value = want_value_q.pop_front();
          if (value_o !== want_value) begin
            $error("value: expected %h, actual %h", want_value, value_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("tb_xorshift_bounded_random: errors");
    $finish;
  end

  task automatic write_seed(input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= 32'($urandom);
    seed_shadow = v;
  endtask

  task automatic wait_drained();
    while (draw_req_q.size() != 0 || want_value_q.size() != 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  task automatic add_req(input kind_e kind, input logic [30:0] bound);
    draw_req_t r;
    r.kind  = kind;
    r.bound = bound;
    draw_req_q.push_back(r);
  endtask

  task automatic start_phase(input logic [31:0] seed_val, input int s_pct, input int r_pct);
    wait_drained();
    write_seed(seed_val);
    @(negedge clk_i);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
  endtask

  task automatic add_random_reqs(input int count);
    int    pick;
    kind_e kind;
    logic [30:0] bound;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8)       kind = KIND_RESEED;
      else if (pick < 30) kind = KIND_RAW32;
      else if (pick < 50) kind = KIND_RAW64;
      else                kind = KIND_BOUNDED;
      case ($urandom_range(9))
        0:       bound = '0;
        1:       bound = 31'h7FFF_FFFF;
        2, 3:    bound = 31'($urandom_range(16, 1));
        4:       bound = 31'(1) << $urandom_range(30);
        default: bound = 31'($urandom);
      endcase
      add_req(kind, bound);
    end
  endtask

  initial begin
    seed_shadow = 32'd0;
    reseed_words(32'd0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: reset state, field extremes, bound zero, heavy rejection bounds
    add_req(KIND_RAW32,   31'h0000_0000);
    add_req(KIND_RAW64,   31'h7FFF_FFFF);
    add_req(KIND_BOUNDED, 31'h0000_0001);
    add_req(KIND_BOUNDED, 31'h0000_0002);
    add_req(KIND_BOUNDED, 31'h7FFF_FFFF);
    add_req(KIND_BOUNDED, 31'h0000_0000);
    add_req(KIND_BOUNDED, 31'h4000_0001);
    add_req(KIND_BOUNDED, 31'h0000_0003);
    add_req(KIND_BOUNDED, 31'h5555_5556);
    add_req(KIND_RESEED,  31'h7FFF_FFFF);
    add_req(KIND_RAW32,   31'h2AAA_AAAA);
    add_req(KIND_RAW64,   31'h0000_0000);
    add_req(KIND_BOUNDED, 31'h4000_0000);
    add_req(KIND_BOUNDED, 31'h0000_0006);
    add_req(KIND_RESEED,  31'h0000_0000);
    add_req(KIND_BOUNDED, 31'h0000_0000);
    add_req(KIND_RAW32,   31'h5555_5555);

    start_phase(32'hFFFF_FFFF, 0, 0);
    add_random_reqs(200);
    start_phase(32'd1, 61, 0);
    add_random_reqs(200);
    start_phase(32'($urandom), 0, 61);
    add_random_reqs(200);
    start_phase(32'h8000_0000, 36, 36);
    hold_arm = 1'b1;
    add_random_reqs(230);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0 && want_value_q.size() == 0) begin
      $display("tb_xorshift_bounded_random: clean");
    end else begin
      $display("tb_xorshift_bounded_random: errors");
    end
    $finish;
  end

endmodule
